/* hdl/bwtt_pkg.sv */
// ---------------------------------------------------------------------------
// bwtt_pkg
// shared types, request and kind codes and sizes for the debug trigger table
// ---------------------------------------------------------------------------
package bwtt_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] REQ_ADD_BREAK   = 3'd0;
    localparam logic [2:0] REQ_ADD_WATCH   = 3'd1;
    localparam logic [2:0] REQ_REMOVE      = 3'd2;
    localparam logic [2:0] REQ_ENABLE      = 3'd3;
    localparam logic [2:0] REQ_DISABLE     = 3'd4;
    localparam logic [2:0] REQ_CHECK_EXEC  = 3'd5;
    localparam logic [2:0] REQ_CHECK_READ  = 3'd6;
    localparam logic [2:0] REQ_CHECK_WRITE = 3'd7;

    localparam logic [1:0] KIND_BP_PC      = 2'd0;
    localparam logic [1:0] KIND_BP_CYCLE   = 2'd1;
    localparam logic [1:0] KIND_BP_RETIRED = 2'd2;
    localparam logic [1:0] KIND_WP_READ    = 2'd0;
    localparam logic [1:0] KIND_WP_WRITE   = 2'd1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  kind;
        logic [63:0] match_value;
        logic [31:0] entry_id;
        logic [63:0] pc;
        logic [63:0] cycle_count;
        logic [63:0] retired_count;
        logic [31:0] access_addr;
        logic [31:0] access_size;
    } t_in_req;

    typedef struct packed {
        logic [31:0] assigned_id;
        logic        done_res;
        logic        hit;
        logic        table_full;
    } t_out_res;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic last_slot;
    } t_dp_stat;

endpackage

/* hdl/breakpoint_watchpoint_trigger_table_core.sv */
// ---------------------------------------------------------------------------
// breakpoint_watchpoint_trigger_table_core
// debug trigger table with breakpoint and watchpoint slots
// ---------------------------------------------------------------------------
// a request is accepted in idle, then the scan unit visits one slot per cycle
//   across all slots, and the commit writes the result register once it is free
// no new request is taken until the core is through with the last one
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active low; all slots invalid, next id is one
module breakpoint_watchpoint_trigger_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bwtt_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bwtt_pkg::t_out_res o_out_data
);

    bwtt_pkg::t_ctl_cmd cmd;
    bwtt_pkg::t_dp_stat stat;

    bwtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bwtt_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_out_data)
    );

endmodule

/* hdl/bwtt_datapath.sv */
// ---------------------------------------------------------------------------
// bwtt_datapath
// slot storage, one-slot-per-cycle scan unit, id counter and result register
// ---------------------------------------------------------------------------
module bwtt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bwtt_pkg::t_in_req  i_req,
    input  bwtt_pkg::t_ctl_cmd i_cmd,
    output bwtt_pkg::t_dp_stat o_stat,
    output bwtt_pkg::t_out_res o_res
);

    logic                         r_valid    [bwtt_pkg::SLOTS];
    logic                         r_is_watch [bwtt_pkg::SLOTS];
    logic [1:0]                   r_kind     [bwtt_pkg::SLOTS];
    logic                         r_enabled  [bwtt_pkg::SLOTS];
    logic [63:0]                  r_value    [bwtt_pkg::SLOTS];
    logic [31:0]                  r_start    [bwtt_pkg::SLOTS];
    logic [31:0]                  r_len      [bwtt_pkg::SLOTS];
    logic [31:0]                  r_ident    [bwtt_pkg::SLOTS];
    logic [31:0]                  r_id_cnt;

    bwtt_pkg::t_in_req            r_req;
    logic [bwtt_pkg::SLOT_IW-1:0] r_idx;
    logic [bwtt_pkg::SLOT_IW-1:0] r_sel;
    logic                         r_found;
    logic                         r_hit;
    bwtt_pkg::t_out_res           r_res;

    logic        is_add;
    logic        is_id_op;
    logic        s_valid;
    logic        s_watch;
    logic [1:0]  s_kind;
    logic        s_en;
    logic [63:0] s_value;
    logic [31:0] s_start;
    logic [31:0] s_len;
    logic [31:0] s_ident;
    logic [31:0] slot_end;
    logic [31:0] acc_end;
    logic        overlap;
    logic        bp_fire;
    logic        wp_fire;
    logic        cand;
    logic        fire;

    assign is_add   = (r_req.req_type == bwtt_pkg::REQ_ADD_BREAK) ||
                      (r_req.req_type == bwtt_pkg::REQ_ADD_WATCH);
    assign is_id_op = (r_req.req_type == bwtt_pkg::REQ_REMOVE) ||
                      (r_req.req_type == bwtt_pkg::REQ_ENABLE) ||
                      (r_req.req_type == bwtt_pkg::REQ_DISABLE);

    // slot under scan
    assign s_valid = r_valid[r_idx];
    assign s_watch = r_is_watch[r_idx];
    assign s_kind  = r_kind[r_idx];
    assign s_en    = r_enabled[r_idx];
    assign s_value = r_value[r_idx];
    assign s_start = r_start[r_idx];
    assign s_len   = r_len[r_idx];
    assign s_ident = r_ident[r_idx];

    assign slot_end = s_start + s_len;
    assign acc_end  = r_req.access_addr + r_req.access_size;
    assign overlap  = (r_req.access_addr < slot_end) && (s_start < acc_end);

    assign bp_fire = ((s_kind == bwtt_pkg::KIND_BP_PC) && (r_req.pc == s_value)) ||
                     ((s_kind == bwtt_pkg::KIND_BP_CYCLE) &&
                      (r_req.cycle_count >= s_value)) ||
                     ((s_kind == bwtt_pkg::KIND_BP_RETIRED) &&
                      (r_req.retired_count >= s_value));

    assign wp_fire = overlap &&
                     !((r_req.req_type == bwtt_pkg::REQ_CHECK_READ) &&
                       (s_kind == bwtt_pkg::KIND_WP_WRITE)) &&
                     !((r_req.req_type == bwtt_pkg::REQ_CHECK_WRITE) &&
                       (s_kind == bwtt_pkg::KIND_WP_READ));

    always_comb begin
        cand = 1'b0;
        fire = 1'b0;
        unique case (r_req.req_type)
            bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::REQ_ADD_WATCH: begin
                cand = !s_valid;
            end
            bwtt_pkg::REQ_REMOVE, bwtt_pkg::REQ_ENABLE, bwtt_pkg::REQ_DISABLE: begin
                cand = s_valid && (s_ident == r_req.entry_id);
            end
            bwtt_pkg::REQ_CHECK_EXEC: begin
                fire = s_valid && s_en && !s_watch && bp_fire;
            end
            default: begin
                fire = s_valid && s_en && s_watch && wp_fire;
            end
        endcase
    end

    assign o_stat.last_slot = (r_idx == bwtt_pkg::SLOT_IW'(bwtt_pkg::SLOTS - 1));
    assign o_res = r_res;

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= bwtt_pkg::SLOT_IW'(r_idx + 1'b1);
            if (cand && !r_found) begin
                r_found <= 1'b1;
            end
            if (fire) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.step && cand && !r_found) begin
            r_sel <= r_idx;
        end
        if (i_cmd.commit) begin
            r_res.assigned_id <= (is_add && r_found) ? r_id_cnt : 32'd0;
            r_res.done_res    <= is_id_op && r_found;
            r_res.hit         <= r_hit;
            r_res.table_full  <= is_add && !r_found;
        end
    end

    // table update on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_cnt <= 32'd1;
            for (int i = 0; i < bwtt_pkg::SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_cmd.commit && r_found) begin
            if (is_add) begin
                r_id_cnt       <= r_id_cnt + 32'd1;
                r_valid[r_sel] <= 1'b1;
            end else if (r_req.req_type == bwtt_pkg::REQ_REMOVE) begin
                r_valid[r_sel] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_found) begin
            if (is_add) begin
                r_enabled[r_sel] <= 1'b1;
                r_kind[r_sel]    <= r_req.kind;
                r_ident[r_sel]   <= r_id_cnt;
                if (r_req.req_type == bwtt_pkg::REQ_ADD_BREAK) begin
                    r_is_watch[r_sel] <= 1'b0;
                    r_value[r_sel]    <= r_req.match_value;
                    r_start[r_sel]    <= 32'd0;
                    r_len[r_sel]      <= 32'd0;
                end else begin
                    r_is_watch[r_sel] <= 1'b1;
                    r_value[r_sel]    <= 64'd0;
                    r_start[r_sel]    <= r_req.access_addr;
                    r_len[r_sel]      <= r_req.access_size;
                end
            end else if (r_req.req_type == bwtt_pkg::REQ_ENABLE) begin
                r_enabled[r_sel] <= 1'b1;
            end else if (r_req.req_type == bwtt_pkg::REQ_DISABLE) begin
                r_enabled[r_sel] <= 1'b0;
            end
        end
    end

endmodule

/* hdl/bwtt_ctrl.sv */
// ---------------------------------------------------------------------------
// bwtt_ctrl
// request sequencer: accept, scan all slots, commit and hand off the result
// ---------------------------------------------------------------------------
module bwtt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  bwtt_pkg::t_dp_stat i_stat,
    output bwtt_pkg::t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_slot) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/bwtt_checker.sv */
// ---------------------------------------------------------------------------
// bwtt_checker
// port-level checks for the debug trigger table
// ---------------------------------------------------------------------------
module bwtt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input bwtt_pkg::t_in_req  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bwtt_pkg::t_out_res o_out_data
);

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while a previous one is still in flight");

    // a new result only comes out of a request under work
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced without a request in flight");

    // at most one kind of outcome per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones({(o_out_data.assigned_id != 32'd0),
            o_out_data.done_res, o_out_data.hit, o_out_data.table_full}) <= 1))
        else $error("result carries more than one outcome");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind breakpoint_watchpoint_trigger_table_core bwtt_checker u_bwtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* tb/breakpoint_watchpoint_trigger_table_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// breakpoint_watchpoint_trigger_table_core_tb
// Self-checking bench for the debug trigger table. A directed list covers
// full-table adds, id lookups, kind filtering, unknown kinds, wrapping and
// empty ranges. A random mix of add, remove, enable, disable and check
// requests follows, with slot churn and clearing sweeps. Each accepted
// request runs through a local trigger table model, and every result is
// compared in order, with bursty requests and a patterned result stall.
// ---------------------------------------------------------------------------
module breakpoint_watchpoint_trigger_table_core_tb;

    localparam logic [1:0] KIND_WP_RDWR = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;
    localparam int N_RANDOM    = 1450;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    bwtt_pkg::t_in_req  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    bwtt_pkg::t_out_res out_data;

    // trigger table model state
    logic        tbl_valid [bwtt_pkg::SLOTS];
    logic        tbl_watch [bwtt_pkg::SLOTS];
    logic        tbl_on    [bwtt_pkg::SLOTS];
    logic [1:0]  tbl_kind  [bwtt_pkg::SLOTS];
    logic [63:0] tbl_value [bwtt_pkg::SLOTS];
    logic [31:0] tbl_start [bwtt_pkg::SLOTS];
    logic [31:0] tbl_len   [bwtt_pkg::SLOTS];
    logic [31:0] tbl_ident [bwtt_pkg::SLOTS];
    logic [31:0] next_ident;

    bwtt_pkg::t_in_req  pending_reqs[$];
    bwtt_pkg::t_out_res expected_res[$];
    logic [31:0]        live_ids[$];
    logic [31:0]        gen_next_id;

    bit                 req_taken;
    int                 err_cnt;
    int                 cycle_cnt;
    int                 gap_left;
    int                 burst_left;
    int                 seg_left;
    t_stall_mode        stall_mode;
    bwtt_pkg::t_out_res want_res;

    breakpoint_watchpoint_trigger_table_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic bwtt_pkg::t_out_res trig_predict(input bwtt_pkg::t_in_req r);
        bwtt_pkg::t_out_res res;
        int                 slot;
        int                 i;
        logic [31:0]        a_end;
        logic [31:0]        b_end;
        res  = '0;
        slot = -1;
        unique case (r.req_type)
            bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::REQ_ADD_WATCH: begin
                for (i = bwtt_pkg::SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) slot = i;
                if (slot < 0) begin
                    res.table_full = 1'b1;
                end else begin
                    res.assigned_id = next_ident;
                    next_ident      = next_ident + 32'd1;
                    tbl_valid[slot] = 1'b1;
                    tbl_on[slot]    = 1'b1;
                    tbl_kind[slot]  = r.kind;
                    tbl_ident[slot] = res.assigned_id;
                    tbl_watch[slot] = (r.req_type == bwtt_pkg::REQ_ADD_WATCH);
                    tbl_value[slot] = tbl_watch[slot] ? 64'd0 : r.match_value;
                    tbl_start[slot] = tbl_watch[slot] ? r.access_addr : 32'd0;
                    tbl_len[slot]   = tbl_watch[slot] ? r.access_size : 32'd0;
                end
            end
            bwtt_pkg::REQ_REMOVE, bwtt_pkg::REQ_ENABLE, bwtt_pkg::REQ_DISABLE: begin
                for (i = bwtt_pkg::SLOTS - 1; i >= 0; i--)
                    if (tbl_valid[i] && tbl_ident[i] == r.entry_id) slot = i;
                if (slot >= 0) begin
                    res.done_res = 1'b1;
                    if (r.req_type == bwtt_pkg::REQ_REMOVE)
                        tbl_valid[slot] = 1'b0;
                    else
                        tbl_on[slot] = (r.req_type == bwtt_pkg::REQ_ENABLE);
                end
            end
            bwtt_pkg::REQ_CHECK_EXEC: begin
                for (i = 0; i < bwtt_pkg::SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_on[i] && !tbl_watch[i]) begin
                        unique case (tbl_kind[i])
                            bwtt_pkg::KIND_BP_PC:
                                if (r.pc == tbl_value[i]) res.hit = 1'b1;
                            bwtt_pkg::KIND_BP_CYCLE:
                                if (r.cycle_count >= tbl_value[i]) res.hit = 1'b1;
                            bwtt_pkg::KIND_BP_RETIRED:
                                if (r.retired_count >= tbl_value[i]) res.hit = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            default: begin
                for (i = 0; i < bwtt_pkg::SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_on[i] && tbl_watch[i]
                        && !(r.req_type == bwtt_pkg::REQ_CHECK_READ
                             && tbl_kind[i] == bwtt_pkg::KIND_WP_WRITE)
                        && !(r.req_type == bwtt_pkg::REQ_CHECK_WRITE
                             && tbl_kind[i] == bwtt_pkg::KIND_WP_READ)) begin
                        // both ends wrap at 32 bits
                        a_end = r.access_addr + r.access_size;
                        b_end = tbl_start[i] + tbl_len[i];
                        if (r.access_addr < b_end && tbl_start[i] < a_end) res.hit = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // every field random, then the fields that matter get overwritten
    function automatic bwtt_pkg::t_in_req noise_req(input logic [2:0] rt);
        bwtt_pkg::t_in_req r;
        r.req_type      = rt;
        r.kind          = 2'($urandom_range(0, 3));
        r.match_value   = rand64();
        r.entry_id      = $urandom();
        r.pc            = rand64();
        r.cycle_count   = rand64();
        r.retired_count = rand64();
        r.access_addr   = $urandom();
        r.access_size   = $urandom();
        return r;
    endfunction

    function automatic void add_entry(input logic [2:0] rt, input logic [1:0] k,
                                      input logic [63:0] v, input logic [31:0] addr,
                                      input logic [31:0] len);
        bwtt_pkg::t_in_req r;
        r      = noise_req(rt);
        r.kind = k;
        if (rt == bwtt_pkg::REQ_ADD_BREAK) begin
            r.match_value = v;
        end else begin
            r.access_addr = addr;
            r.access_size = len;
        end
        pending_reqs.push_back(r);
        if (live_ids.size() < bwtt_pkg::SLOTS) begin
            live_ids.push_back(gen_next_id);
            gen_next_id = gen_next_id + 32'd1;
        end
    endfunction

    function automatic void id_req(input logic [2:0] rt, input logic [31:0] id);
        bwtt_pkg::t_in_req r;
        int                j;
        r          = noise_req(rt);
        r.entry_id = id;
        pending_reqs.push_back(r);
        if (rt == bwtt_pkg::REQ_REMOVE) begin
            for (j = 0; j < live_ids.size(); j++) begin
                if (live_ids[j] == id) begin
                    live_ids.delete(j);
                    break;
                end
            end
        end
    endfunction

    function automatic void chk_exec(input logic [63:0] pc, input logic [63:0] cyc,
                                     input logic [63:0] ret);
        bwtt_pkg::t_in_req r;
        r               = noise_req(bwtt_pkg::REQ_CHECK_EXEC);
        r.pc            = pc;
        r.cycle_count   = cyc;
        r.retired_count = ret;
        pending_reqs.push_back(r);
    endfunction

    function automatic void chk_access(input logic [2:0] rt, input logic [31:0] addr,
                                       input logic [31:0] len);
        bwtt_pkg::t_in_req r;
        r             = noise_req(rt);
        r.access_addr = addr;
        r.access_size = len;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [63:0] pick_pc();
        unique case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            2:       return rand64();
            default: return 64'h0000_0000_8000_0000 + 64'd4 * $urandom_range(0, 7);
        endcase
    endfunction

    function automatic logic [63:0] pick_count();
        unique case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            default: return rand64() >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        unique case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: return 32'h0000_1000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [31:0] pick_len();
        unique case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return '1;
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    function automatic logic [31:0] pick_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7 && live_ids.size() != 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        if (sel == 9)
            return $urandom();
        return gen_next_id + 32'd1 - $urandom_range(0, 12);
    endfunction

    function automatic logic [1:0] pick_kind();
        return ($urandom_range(0, 15) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
    endfunction

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || req_taken) begin
                if (gap_left != 0 || pending_reqs.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end else begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            if (seg_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                seg_left   = $urandom_range(10, 150);
            end else begin
                seg_left--;
            end
            unique case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (seg_left % 16 < 12);
            endcase
        end
    end

    // request and result monitor
    always @(posedge clk) begin
        req_taken = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_res.size() == 0) begin
                    $error("result with no request pending: %h", out_data);
                    err_cnt++;
                end else begin
                    want_res = expected_res.pop_front();
                    if (out_data.assigned_id !== want_res.assigned_id) begin
                        $error("assigned_id mismatch: expected %0h actual %0h",
                               want_res.assigned_id, out_data.assigned_id);
                        err_cnt++;
                    end
                    if (out_data.done_res !== want_res.done_res) begin
                        $error("done_res mismatch: expected %0b actual %0b",
                               want_res.done_res, out_data.done_res);
                        err_cnt++;
                    end
                    if (out_data.hit !== want_res.hit) begin
                        $error("hit mismatch: expected %0b actual %0b",
                               want_res.hit, out_data.hit);
                        err_cnt++;
                    end
                    if (out_data.table_full !== want_res.table_full) begin
                        $error("table_full mismatch: expected %0b actual %0b",
                               want_res.table_full, out_data.table_full);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                req_taken = 1'b1;
                expected_res.push_back(trig_predict(in_data));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] sweep[$];
        int          n;
        int          sel;
        int          j;
        for (j = 0; j < bwtt_pkg::SLOTS; j++) begin
            tbl_valid[j] = 1'b0;
            tbl_watch[j] = 1'b0;
            tbl_on[j]    = 1'b0;
            tbl_kind[j]  = '0;
            tbl_value[j] = '0;
            tbl_start[j] = '0;
            tbl_len[j]   = '0;
            tbl_ident[j] = '0;
        end
        next_ident  = 32'd1;
        gen_next_id = 32'd1;

        // directed
        chk_exec('1, '1, '1);
        chk_access(bwtt_pkg::REQ_CHECK_READ, 32'd0, '1);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::KIND_BP_PC, '1, '0, '0);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::KIND_BP_CYCLE,
                  64'h8000_0000_0000_0000, '0, '0);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::KIND_BP_RETIRED, 64'd0, '0, '0);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, KIND_BAD, 64'd0, '0, '0);
        add_entry(bwtt_pkg::REQ_ADD_WATCH, bwtt_pkg::KIND_WP_READ, '0,
                  32'h0000_1000, 32'h10);
        add_entry(bwtt_pkg::REQ_ADD_WATCH, bwtt_pkg::KIND_WP_WRITE, '0,
                  32'h0000_2000, 32'h10);
        add_entry(bwtt_pkg::REQ_ADD_WATCH, KIND_WP_RDWR, '0, 32'hFFFF_FFF0, 32'h20);
        add_entry(bwtt_pkg::REQ_ADD_WATCH, KIND_BAD, '0, 32'h0000_3000, 32'd0);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::KIND_BP_PC, 64'd5, '0, '0);
        add_entry(bwtt_pkg::REQ_ADD_WATCH, bwtt_pkg::KIND_WP_READ, '0, '1, '1);
        chk_exec('1, 64'd0, 64'd0);
        id_req(bwtt_pkg::REQ_DISABLE, 32'd3);
        chk_exec(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        chk_exec(64'd0, 64'h8000_0000_0000_0000, 64'd0);
        chk_access(bwtt_pkg::REQ_CHECK_WRITE, 32'h0000_1008, 32'd4);
        chk_access(bwtt_pkg::REQ_CHECK_READ, 32'h0000_1008, 32'd4);
        chk_access(bwtt_pkg::REQ_CHECK_READ, 32'h0000_2000, 32'd8);
        chk_access(bwtt_pkg::REQ_CHECK_WRITE, 32'h0000_3000, 32'd0);
        chk_access(bwtt_pkg::REQ_CHECK_WRITE, 32'h0000_0008, 32'd0);
        id_req(bwtt_pkg::REQ_REMOVE, '1);
        id_req(bwtt_pkg::REQ_ENABLE, 32'd3);
        id_req(bwtt_pkg::REQ_REMOVE, 32'd1);
        id_req(bwtt_pkg::REQ_REMOVE, 32'd1);
        add_entry(bwtt_pkg::REQ_ADD_BREAK, bwtt_pkg::KIND_BP_PC, 64'd0, '0, '0);
        chk_exec(64'd0, 64'd0, 64'd0);

        // random mix
        for (n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                sweep = live_ids;
                foreach (sweep[k]) id_req(bwtt_pkg::REQ_REMOVE, sweep[k]);
            end else if (sel < 13) begin
                add_entry(bwtt_pkg::REQ_ADD_BREAK, pick_kind(),
                          ($urandom_range(0, 1) != 0) ? pick_pc() : pick_count(), '0, '0);
            end else if (sel < 24) begin
                add_entry(bwtt_pkg::REQ_ADD_WATCH, pick_kind(), '0, pick_addr(), pick_len());
            end else if (sel < 35) begin
                id_req(bwtt_pkg::REQ_REMOVE, pick_id());
            end else if (sel < 41) begin
                id_req(bwtt_pkg::REQ_ENABLE, pick_id());
            end else if (sel < 47) begin
                id_req(bwtt_pkg::REQ_DISABLE, pick_id());
            end else if (sel < 67) begin
                chk_exec(pick_pc(), pick_count(), pick_count());
            end else if (sel < 84) begin
                chk_access(bwtt_pkg::REQ_CHECK_READ, pick_addr(), pick_len());
            end else begin
                chk_access(bwtt_pkg::REQ_CHECK_WRITE, pick_addr(), pick_len());
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
        while (expected_res.size() != 0) @(posedge clk);
        repeat (bwtt_pkg::SLOTS + 4) @(posedge clk);
        @(negedge clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
